[rtl/rar_pkg.sv]
package rar_pkg;

	localparam int OPW_MAX = 32;
	localparam int DW = 64;
	localparam int NUM_W = 33;
	localparam int DEN_W = 32;
	localparam int CNT_W = 32;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		K_SHARED_ADD,
		K_SHARED_SUB,
		K_CROSS_ADD,
		K_CROSS_SUB,
		K_MUL,
		K_DIV
	} kind_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL,
		B_CHECK,
		B_GCD,
		B_TEST,
		B_DIVN,
		B_DIVD,
		B_FIN
	} back_state_t;

	typedef struct packed {
		op_t                        op;
		kind_t                      kind;
		logic signed [OPW_MAX-1:0]  an;
		logic signed [OPW_MAX-1:0]  ad;
		logic signed [OPW_MAX-1:0]  bn;
		logic signed [OPW_MAX-1:0]  bd;
	} rar_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rar_fifo_st_t;

endpackage

[rtl/rational_arith_reduce.sv]
// channel  dir  handshake             beat
// in       in   in_valid / in_stall   op, a_num, a_den, b_num, b_den
// out      out  out_valid / out_stall res_num, res_den, was_reduced, zero_den,
//                                     op_count, reduce_count
//
// One item at a time in the back end: when the denominator is not positive the
// result goes out unreduced; otherwise a binary gcd over 64 bits runs on a nonzero
// numerator, one step a cycle, and a reduction adds two divisions in the shared
// radix-2 divider.
// Multiplies go one per cycle through a single 32x32 multiplier.
// A two-entry queue holds accepted beats while the back end is busy.
// Reset clears the queue, the sequencer and all counters.
// in_stall is high when the queue is full; out_stall holds the output register.
module rational_arith_reduce
	import rar_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [NUM_W-1:0]         res_num,
	output logic signed [DEN_W-1:0]         res_den,
	output logic                            was_reduced,
	output logic                            zero_den,
	output logic [CNT_W-1:0]                op_count,
	output logic [CNT_W-1:0]                reduce_count
);

	rar_cmd_t     front_cmd, back_cmd;
	rar_fifo_st_t fst;
	logic         push, pop;

	assign in_stall = fst.full;

	rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.in_valid (in_valid),
		.fst      (fst),
		.op       (op),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.push     (push),
		.cmd      (front_cmd)
	);

	rar_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.pop    (pop),
		.rdata  (back_cmd),
		.st     (fst)
	);

	rar_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (back_cmd),
		.fst          (fst),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.res_num      (res_num),
		.res_den      (res_den),
		.was_reduced  (was_reduced),
		.zero_den     (zero_den),
		.op_count     (op_count),
		.reduce_count (reduce_count)
	);

	a_fifo_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(fst.full && fst.empty))
		else $error("queue full and empty at once");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fst.empty)
		else $error("pop from empty queue");

	a_zero_not_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_den) |-> !was_reduced)
		else $error("zero denominator flagged as reduced");

	a_reduced_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_reduced) |-> (res_den != '0))
		else $error("reduced result with zero denominator");

endmodule

[rtl/rar_front.sv]
module rar_front
	import rar_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                            in_valid,
	input  rar_fifo_st_t                    fst,
	input  logic [1:0]                      op,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                            push,
	output rar_cmd_t                        cmd
);

	logic same_den;

	assign same_den = (a_den == b_den);
	assign push = in_valid && !fst.full;

	always_comb begin
		cmd.op = op_t'(op);
		cmd.an = OPW_MAX'(a_num);
		cmd.ad = OPW_MAX'(a_den);
		cmd.bn = OPW_MAX'(b_num);
		cmd.bd = OPW_MAX'(b_den);
		case (op_t'(op))
			OP_ADD: cmd.kind = same_den ? K_SHARED_ADD : K_CROSS_ADD;
			OP_SUB: cmd.kind = same_den ? K_SHARED_SUB : K_CROSS_SUB;
			OP_MUL: cmd.kind = K_MUL;
			default: cmd.kind = K_DIV;
		endcase
	end

endmodule

[rtl/rar_fifo.sv]
module rar_fifo
	import rar_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  rar_cmd_t     wdata,
	input  logic         pop,
	output rar_cmd_t     rdata,
	output rar_fifo_st_t st
);

	rar_cmd_t   mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign st.full = (cnt_q == 2'd2);
	assign st.empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/rar_div.sv]
module rar_div
	import rar_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW);

	logic [DW-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial, diff;
	logic          ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign ge = !diff[DW];
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(DW-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW-1)) busy_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/rar_back.sv]
module rar_back
	import rar_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  rar_cmd_t                cmd,
	input  rar_fifo_st_t            fst,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [NUM_W-1:0] res_num,
	output logic signed [DEN_W-1:0] res_den,
	output logic                    was_reduced,
	output logic                    zero_den,
	output logic [CNT_W-1:0]        op_count,
	output logic [CNT_W-1:0]        reduce_count
);

	back_state_t state_q, state_d;
	rar_cmd_t    ent_q;
	logic [1:0]  mcnt_q, nprod, cidx;
	logic signed [OPW_MAX-1:0] ma, mb;
	logic signed [DW-1:0]      prod, p_q;
	logic [DW-1:0] n_q, d_q, mag_q, g_q, gx_q, gy_q, nmag;
	logic [5:0]    gk_q;
	logic          nneg_q, red_q, d_pos, is_sub;
	logic          div_start, div_done;
	logic [DW-1:0] div_a, div_quo;
	logic [CNT_W-1:0] op_cnt_q [4];
	logic [CNT_W-1:0] red_cnt_q;
	logic          out_valid_q, out_free;

	assign nprod = (ent_q.kind == K_CROSS_ADD || ent_q.kind == K_CROSS_SUB) ? 2'd3 : 2'd2;
	assign cidx = mcnt_q - 2'd1;
	assign is_sub = (ent_q.kind == K_CROSS_SUB);
	assign d_pos = !d_q[DW-1] && (d_q != '0);
	assign nmag = n_q[DW-1] ? ('0 - n_q) : n_q;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// shared multiplier operand select
	always_comb begin
		ma = ent_q.ad;
		mb = ent_q.bd;
		case (ent_q.kind)
			K_MUL: begin
				if (mcnt_q == 2'd1) begin ma = ent_q.an; mb = ent_q.bn; end
			end
			K_DIV: begin
				if (mcnt_q == 2'd0) begin ma = ent_q.ad; mb = ent_q.bn; end
				else begin ma = ent_q.an; mb = ent_q.bd; end
			end
			default: begin
				if (mcnt_q == 2'd1) begin ma = ent_q.an; mb = ent_q.bd; end
				else if (mcnt_q == 2'd2) begin ma = ent_q.bn; mb = ent_q.ad; end
			end
		endcase
	end

	assign prod = ma * mb;

	rar_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!fst.empty) begin
					if (cmd.kind == K_SHARED_ADD || cmd.kind == K_SHARED_SUB) state_d = B_CHECK;
					else state_d = B_MUL;
				end
			end
			B_MUL: if (mcnt_q == nprod) state_d = B_CHECK;
			B_CHECK: begin
				if (!d_pos) state_d = B_FIN;
				else if (nmag == '0) state_d = B_TEST;
				else state_d = B_GCD;
			end
			B_GCD: if (gx_q == gy_q) state_d = B_TEST;
			B_TEST: state_d = (g_q > DW'(1)) ? B_DIVN : B_FIN;
			B_DIVN: if (div_done) state_d = B_DIVD;
			B_DIVD: if (div_done) state_d = B_FIN;
			B_FIN: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		div_start = 1'b0;
		div_a = mag_q;
		case (state_q)
			B_IDLE: pop = !fst.empty;
			B_TEST: div_start = (g_q > DW'(1));
			B_DIVN: begin
				div_start = div_done;
				div_a = d_q;
			end
			default: begin
				pop = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ent_q <= cmd;
				mcnt_q <= 2'd0;
				red_q <= 1'b0;
				d_q <= DW'(cmd.ad);
				if (cmd.kind == K_SHARED_SUB) n_q <= DW'(cmd.an) - DW'(cmd.bn);
				else n_q <= DW'(cmd.an) + DW'(cmd.bn);
			end
			B_MUL: begin
				if (mcnt_q != nprod) p_q <= prod;
				if (mcnt_q != 2'd0) begin
					case (cidx)
						2'd0: d_q <= p_q;
						2'd1: n_q <= p_q;
						default: n_q <= is_sub ? n_q - p_q : n_q + p_q;
					endcase
				end
				mcnt_q <= mcnt_q + 2'd1;
			end
			B_CHECK: begin
				nneg_q <= n_q[DW-1];
				mag_q <= nmag;
				g_q <= d_q;
				gx_q <= nmag;
				gy_q <= d_q;
				gk_q <= '0;
			end
			B_GCD: begin
				// binary gcd, one shift or subtract a cycle
				if (gx_q == gy_q) g_q <= gx_q << gk_q;
				else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					gk_q <= gk_q + 6'd1;
				end else if (!gx_q[0]) gx_q <= gx_q >> 1;
				else if (!gy_q[0]) gy_q <= gy_q >> 1;
				else if (gx_q > gy_q) gx_q <= (gx_q - gy_q) >> 1;
				else gy_q <= (gy_q - gx_q) >> 1;
			end
			B_DIVN: if (div_done) n_q <= nneg_q ? ('0 - div_quo) : div_quo;
			B_DIVD: begin
				if (div_done) begin
					d_q <= div_quo;
					red_q <= 1'b1;
				end
			end
			B_FIN: begin
				if (out_free) begin
					res_num <= n_q[NUM_W-1:0];
					res_den <= d_q[DEN_W-1:0];
					was_reduced <= red_q;
					zero_den <= (d_q == '0);
					op_count <= op_cnt_q[ent_q.op] + CNT_W'(1);
					reduce_count <= red_cnt_q + CNT_W'(red_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			red_cnt_q <= '0;
			for (int i = 0; i < 4; i++) op_cnt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_FIN && out_free) begin
				out_valid_q <= 1'b1;
				op_cnt_q[ent_q.op] <= op_cnt_q[ent_q.op] + CNT_W'(1);
				red_cnt_q <= red_cnt_q + CNT_W'(red_q);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[tb/rational_arith_reduce_tb.sv]
`timescale 1ns / 100ps

module rational_arith_reduce_tb;
	import rar_pkg::*;

	typedef struct {
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
		logic                    reduced;
		logic                    zden;
		logic [CNT_W-1:0]        opc;
		logic [CNT_W-1:0]        redc;
	} frac_res_t;

	class frac_scoreboard;
		logic [CNT_W-1:0] op_tally[4];
		logic [CNT_W-1:0] reduce_tally;
		frac_res_t        pending[$];
		int               errors;

		function new();
			for (int i = 0; i < 4; i++) op_tally[i] = '0;
			reduce_tally = '0;
			errors = 0;
		endfunction

		function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
			logic [63:0] t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		// work out the reduced fraction for one accepted beat
		function void note_operands(op_t opc, logic signed [15:0] an16,
				logic signed [15:0] ad16, logic signed [15:0] bn16,
				logic signed [15:0] bd16);
			logic [63:0] an, ad, bn, bd, n, d, g, mag;
			frac_res_t r;
			an = 64'(signed'(an16));
			ad = 64'(signed'(ad16));
			bn = 64'(signed'(bn16));
			bd = 64'(signed'(bd16));
			r.reduced = 1'b0;
			case (opc)
				OP_ADD: begin
					if (ad == bd) begin
						n = an + bn;
						d = ad;
					end else begin
						d = ad * bd;
						n = an * bd + bn * ad;
					end
				end
				OP_SUB: begin
					if (ad == bd) begin
						n = an - bn;
						d = ad;
					end else begin
						d = ad * bd;
						n = an * bd - bn * ad;
					end
				end
				OP_MUL: begin
					d = ad * bd;
					n = an * bn;
				end
				default: begin
					d = ad * bn;
					n = an * bd;
				end
			endcase
			op_tally[opc] += 1;
			if (d != 0 && !d[63]) begin
				mag = n[63] ? -n : n;
				g = gcd64(mag, d);
				if (g > 1) begin
					n = n[63] ? -(mag / g) : n / g;
					d = d / g;
					r.reduced = 1'b1;
					reduce_tally += 1;
				end
			end
			r.num = n[NUM_W-1:0];
			r.den = d[DEN_W-1:0];
			r.zden = (d == 0);
			r.opc = op_tally[opc];
			r.redc = reduce_tally;
			pending.push_back(r);
		endfunction

		function void check_result(frac_res_t got);
			frac_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result num=%0d den=%0d", $time, got.num, got.den);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.num !== e.num) begin
				$display("%0t: res_num exp %0d got %0d", $time, e.num, got.num);
				errors++;
			end
			if (got.den !== e.den) begin
				$display("%0t: res_den exp %0d got %0d", $time, e.den, got.den);
				errors++;
			end
			if (got.reduced !== e.reduced) begin
				$display("%0t: was_reduced exp %0b got %0b", $time, e.reduced, got.reduced);
				errors++;
			end
			if (got.zden !== e.zden) begin
				$display("%0t: zero_den exp %0b got %0b", $time, e.zden, got.zden);
				errors++;
			end
			if (got.opc !== e.opc) begin
				$display("%0t: op_count exp %0d got %0d", $time, e.opc, got.opc);
				errors++;
			end
			if (got.redc !== e.redc) begin
				$display("%0t: reduce_count exp %0d got %0d", $time, e.redc, got.redc);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          op = '0;
	logic signed [15:0]  a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic                out_valid;
	logic                out_stall = 1'b1;
	logic signed [NUM_W-1:0] res_num;
	logic signed [DEN_W-1:0] res_den;
	logic                was_reduced, zero_den;
	logic [CNT_W-1:0]    op_count, reduce_count;

	frac_scoreboard sb = new();
	bit  quiet_phase = 0;
	bit  hold_off_req = 0;

	rational_arith_reduce #(.OPERAND_WIDTH(16)) i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .op, .a_num, .a_den, .b_num, .b_den,
		.out_valid, .out_stall, .res_num, .res_den, .was_reduced, .zero_den,
		.op_count, .reduce_count
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 12)) - 16'sd6;
			1: return 16'($urandom_range(0, 200)) - 16'sd100;
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			3: return 16'($urandom_range(1, 64)) * 16'($urandom_range(1, 64));
			default: return 16'($urandom);
		endcase
	endfunction

	// present one beat, hold until accepted; valid drops only while idling
	task automatic send_beat(op_t o, logic [15:0] an, logic [15:0] ad,
			logic [15:0] bn, logic [15:0] bd);
		while (!quiet_phase && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (in_stall);
		sb.note_operands(o, an, ad, bn, bd);
	endtask

	// output side: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{res_num, res_den, was_reduced, zero_den, op_count,
				reduce_count});
	end

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				out_stall <= 1'b1;
				for (hold = 0; hold < 3000; hold++) @(posedge clk);
			end
			out_stall <= (!quiet_phase && $urandom_range(0, 99) < 30);
		end
	end

	initial begin
		#(12ns * 5_000_000);
		$display("[rational_arith_reduce] ERROR");
		$finish;
	end

	initial begin
		int i, wait_cyc;
		logic [15:0] d;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, each op, shared denominators, zero num/den, negatives
		send_beat(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
		send_beat(OP_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
		send_beat(OP_ADD, 16'sd1, 16'sd3, 16'sd1, 16'sd6);
		send_beat(OP_SUB, 16'sd1, 16'sd3, 16'sd5, 16'sd7);
		send_beat(OP_MUL, 16'sd2, 16'sd3, 16'sd9, 16'sd4);
		send_beat(OP_DIV, 16'sd2, 16'sd3, 16'sd4, 16'sd9);
		send_beat(OP_DIV, 16'sd2, 16'sd3, 16'sd0, 16'sd9);
		send_beat(OP_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd3);
		send_beat(OP_ADD, 16'sd0, 16'sd1, 16'sd0, 16'sd1);
		send_beat(OP_MUL, 16'sd5, 16'sd0, 16'sd7, 16'sd3);
		send_beat(OP_ADD, 16'sd4, -16'sd6, 16'sd2, -16'sd6);
		send_beat(OP_MUL, -16'sd4, 16'sd6, 16'sd2, 16'sd8);
		send_beat(OP_DIV, -16'sd4, -16'sd6, -16'sd2, 16'sd8);
		send_beat(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_beat(OP_SUB, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_beat(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_beat(OP_DIV, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_beat(OP_SUB, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_beat(OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'sd1);
		send_beat(OP_SUB, 16'sd7, 16'sd1, 16'sd7, 16'sd1);
		// receiver holds off long while sender keeps offering
		hold_off_req = 1;
		for (i = 0; i < 20; i++)
			send_beat(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
		for (i = 0; i < 1830; i++) begin
			quiet_phase = (i >= 600 && i < 800);
			d = rand_operand();
			if ($urandom_range(0, 3) == 0)
				send_beat(op_t'($urandom_range(0, 1)), rand_operand(), d,
					rand_operand(), d);
			else
				send_beat(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
					rand_operand(), rand_operand());
		end
		in_valid <= 1'b0;
		quiet_phase = 0;
		wait_cyc = 0;
		while (sb.pending.size() != 0 && wait_cyc < 200000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[rational_arith_reduce] OK");
		else
			$display("[rational_arith_reduce] ERROR");
		$finish;
	end

endmodule
